>>> rtl/tgab_pkg.sv
package tgab_pkg;

   localparam int ADDR_BITS_DEF = 24;

   localparam int HDR_LEN      = 18;
   localparam int HDR_WIDTH_LO = 12;
   localparam int HDR_WIDTH_HI = 13;
   localparam int HDR_HEIGHT_LO = 14;
   localparam int HDR_HEIGHT_HI = 15;
   localparam int HDR_BPP      = 16;
   localparam int HDR_DESC     = 17;

   localparam logic [7:0] DESC_TOP_DOWN = 8'd32;
   localparam logic [7:0] BPP_RAW       = 8'd16;

   localparam logic [1:0] MODE_RAW    = 2'd0;
   localparam logic [1:0] MODE_TRIPLE = 2'd1;
   localparam logic [1:0] MODE_QUAD   = 2'd2;

   localparam logic [1:0]  LOADER_MODE_RST = MODE_TRIPLE;
   localparam logic [12:0] FB_WIDTH_RST    = 13'd320;

   localparam int CSR_DATA_W = 13;
   localparam logic CSR_LOADER_MODE = 1'b0;
   localparam logic CSR_FB_WIDTH    = 1'b1;

   localparam int RSP_DEPTH = 4;

   typedef enum logic [1:0] {
      KIND_PIXEL = 2'd0,
      KIND_SIZE  = 2'd1,
      KIND_DONE  = 2'd2,
      KIND_FAIL  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] pixel;
      logic [15:0] width;
      logic [15:0] height;
      logic        last;
   } res_type;

   function automatic logic [15:0] pack555(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
      return {1'b0, r[7:3], g[7:3], b[7:3]};
   endfunction

endpackage

>>> rtl/tgab_req_if.sv
interface tgab_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_file;

   modport source (output valid, output in_byte, output end_of_file, input ready);
   modport sink (input valid, input in_byte, input end_of_file, output ready);
endinterface

>>> rtl/tgab_rsp_if.sv
interface tgab_rsp_if #(parameter int ADDR_BITS = 24);
   logic                 valid;
   logic                 ready;
   logic [1:0]           kind;
   logic [ADDR_BITS-1:0] address;
   logic [15:0]          pixel;
   logic [15:0]          width;
   logic [15:0]          height;
   logic                 beyond;
   logic                 last;

   modport source (output valid, output kind, output address, output pixel, output width,
                   output height, output beyond, output last, input ready);
   modport sink (input valid, input kind, input address, input pixel, input width,
                 input height, input beyond, input last, output ready);
endinterface

>>> rtl/tgab_decode.sv
module tgab_decode import tgab_pkg::*; #(
   parameter int ADDR_BITS = ADDR_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic [7:0]           in_byte,
   input  logic                 eof,
   input  logic [1:0]           loader_mode,
   input  logic [12:0]          fb_width,
   output res_type              res_a,
   output logic [ADDR_BITS-1:0] addr_a,
   output logic                 beyond_a,
   output res_type              res_b,
   output logic [1:0]           push_count
);

   localparam int SUM_W = (ADDR_BITS >= 30) ? ADDR_BITS + 1 : 30;

   logic [4:0]  hdr_count_ff, hdr_count_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [7:0]  bpp_ff, bpp_in;
   logic [7:0]  desc_ff, desc_in;
   logic [15:0] row_ff, row_in;
   logic [15:0] col_ff, col_in;
   logic [1:0]  phase_ff, phase_in;
   logic [23:0] held_ff, held_in;

   logic        is_hdr, size_now, active, complete, have_a, hdr_ok;
   logic [4:0]  hdr_count_inc;
   logic [1:0]  mode, phase_last;
   logic [15:0] rows, dest_row, pixel;
   logic [16:0] col_inc;
   logic        col_wrap;
   logic [28:0] prod;
   logic [SUM_W-1:0] sum;
   res_type     res_pix, res_size, res_fin;

   assign is_hdr        = hdr_count_ff < 5'(HDR_LEN);
   assign hdr_count_inc = hdr_count_ff + 5'd1;
   assign size_now      = is_hdr && (hdr_count_inc == 5'(HDR_LEN));
   assign hdr_ok        = !is_hdr || size_now;

   always_comb begin
      if ((loader_mode == MODE_TRIPLE || loader_mode == MODE_QUAD) && bpp_ff != BPP_RAW) begin
         mode = loader_mode;
      end else begin
         mode = MODE_RAW;
      end
   end

   always_comb begin
      unique case (mode)
         MODE_TRIPLE: phase_last = 2'd2;
         MODE_QUAD:   phase_last = 2'd3;
         default:     phase_last = 2'd1;
      endcase
   end

   always_comb begin
      if (mode == MODE_QUAD) begin
         rows = (height_ff == 16'd0) ? 16'd0 : height_ff - 16'd1;
      end else begin
         rows = height_ff;
      end
   end

   assign active   = !is_hdr && (width_ff != 16'd0) && (row_ff < rows);
   assign complete = active && (phase_ff >= phase_last);
   assign have_a   = size_now || complete;

   always_comb begin
      unique case (mode)
         MODE_TRIPLE: pixel = pack555(in_byte, held_ff[15:8], held_ff[7:0]);
         MODE_QUAD:   pixel = pack555(held_ff[23:16], held_ff[15:8], held_ff[7:0]);
         default:     pixel = {in_byte, held_ff[7:0]};
      endcase
   end

   assign dest_row = (desc_ff == DESC_TOP_DOWN) ? row_ff : height_ff - 16'd1 - row_ff;
   assign prod     = 29'(dest_row) * 29'(fb_width);
   assign sum      = SUM_W'(prod) + SUM_W'(col_ff);

   assign col_inc  = {1'b0, col_ff} + 17'd1;
   assign col_wrap = col_inc >= {1'b0, width_ff};

   always_comb begin
      hdr_count_in = hdr_count_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      bpp_in       = bpp_ff;
      desc_in      = desc_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      phase_in     = phase_ff;
      held_in      = held_ff;
      if (is_hdr) begin
         hdr_count_in = hdr_count_inc;
         unique case (hdr_count_ff)
            5'(HDR_WIDTH_LO):  width_in  = {width_ff[15:8], in_byte};
            5'(HDR_WIDTH_HI):  width_in  = {in_byte, width_ff[7:0]};
            5'(HDR_HEIGHT_LO): height_in = {height_ff[15:8], in_byte};
            5'(HDR_HEIGHT_HI): height_in = {in_byte, height_ff[7:0]};
            5'(HDR_BPP):       bpp_in    = in_byte;
            5'(HDR_DESC):      desc_in   = in_byte;
            default: ;
         endcase
      end else if (complete) begin
         phase_in = 2'd0;
         held_in  = 24'd0;
         col_in   = col_wrap ? 16'd0 : col_inc[15:0];
         row_in   = col_wrap ? row_ff + 16'd1 : row_ff;
      end else if (active) begin
         phase_in = phase_ff + 2'd1;
         held_in  = held_ff | (24'(in_byte) << {phase_ff, 3'b000});
      end
   end

   always_comb begin
      res_pix        = '0;
      res_pix.kind   = KIND_PIXEL;
      res_pix.pixel  = pixel;
      res_size        = '0;
      res_size.kind   = KIND_SIZE;
      res_size.width  = width_in;
      res_size.height = height_in;
      res_fin         = '0;
      res_fin.last    = 1'b1;
      if (hdr_ok) begin
         res_fin.kind   = KIND_DONE;
         res_fin.width  = width_in;
         res_fin.height = height_in;
      end else begin
         res_fin.kind   = KIND_FAIL;
      end
   end

   always_comb begin
      res_b    = res_fin;
      addr_a   = '0;
      beyond_a = 1'b0;
      if (size_now) begin
         res_a = res_size;
      end else if (complete) begin
         res_a    = res_pix;
         addr_a   = sum[ADDR_BITS-1:0];
         beyond_a = |sum[SUM_W-1:ADDR_BITS];
      end else begin
         res_a = res_fin;
      end
   end

   assign push_count = fire ? (2'(have_a) + 2'(eof)) : 2'd0;

   always_ff @(posedge clock) begin
      if (reset || (fire && eof)) begin
         hdr_count_ff <= '0;
         width_ff     <= '0;
         height_ff    <= '0;
         bpp_ff       <= '0;
         desc_ff      <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         phase_ff     <= '0;
         held_ff      <= '0;
      end else if (fire) begin
         hdr_count_ff <= hdr_count_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         bpp_ff       <= bpp_in;
         desc_ff      <= desc_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         phase_ff     <= phase_in;
         held_ff      <= held_in;
      end
   end

endmodule

>>> rtl/tga_bmp_stream_to_rgb555_core.sv
// Order: a request is held in the input register, decoded, and its results wait in the result queue until taken.
// Throughput: one request per cycle while the result queue has room; an input register feeds the decode step
// and a four-entry result queue decouples the response side.
// A request may yield two results; intake pauses while fewer than two queue slots are free.
// Reset (synchronous, active high) clears stream state and the queue and sets the registers.
module tga_bmp_stream_to_rgb555_core import tgab_pkg::*; #(
   parameter int ADDR_BITS = ADDR_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   tgab_req_if.sink              req,
   tgab_rsp_if.source            rsp,
   input  logic                  csr_wr_en,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   logic [1:0]  loader_mode_ff;
   logic [12:0] fb_width_ff;

   logic        in_vld_ff;
   logic [7:0]  byte_ff;
   logic        eof_ff;
   logic        fire;

   res_type              res_a, res_b;
   logic [ADDR_BITS-1:0] addr_a;
   logic                 beyond_a;
   logic [1:0]           push_count;

   res_type              q_res_ff  [RSP_DEPTH];
   logic [ADDR_BITS-1:0] q_addr_ff [RSP_DEPTH];
   logic                 q_bey_ff  [RSP_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff, wr_ptr_nxt;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 pop;
   res_type              head;

   always_ff @(posedge clock) begin
      if (reset) begin
         loader_mode_ff <= LOADER_MODE_RST;
         fb_width_ff    <= FB_WIDTH_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LOADER_MODE: loader_mode_ff <= csr_wdata[1:0];
            CSR_FB_WIDTH:    fb_width_ff    <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   assign fire      = in_vld_ff && (count_ff <= CNT_W'(RSP_DEPTH - 2));
   assign req.ready = !in_vld_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req.ready) begin
         in_vld_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         byte_ff <= req.in_byte;
         eof_ff  <= req.end_of_file;
      end
   end

   tgab_decode #(.ADDR_BITS(ADDR_BITS)) u_decode (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .in_byte    (byte_ff),
      .eof        (eof_ff),
      .loader_mode(loader_mode_ff),
      .fb_width   (fb_width_ff),
      .res_a      (res_a),
      .addr_a     (addr_a),
      .beyond_a   (beyond_a),
      .res_b      (res_b),
      .push_count (push_count)
   );

   assign pop        = (count_ff != '0) && rsp.ready;
   assign wr_ptr_nxt = wr_ptr_ff + PTR_W'(1);
   assign count_in   = count_ff - CNT_W'(pop) + CNT_W'(push_count);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + PTR_W'(push_count);
         rd_ptr_ff <= rd_ptr_ff + PTR_W'(pop);
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         q_res_ff[wr_ptr_ff]  <= res_a;
         q_addr_ff[wr_ptr_ff] <= addr_a;
         q_bey_ff[wr_ptr_ff]  <= beyond_a;
      end
      if (push_count == 2'd2) begin
         q_res_ff[wr_ptr_nxt]  <= res_b;
         q_addr_ff[wr_ptr_nxt] <= '0;
         q_bey_ff[wr_ptr_nxt]  <= 1'b0;
      end
   end

   assign head        = q_res_ff[rd_ptr_ff];
   assign rsp.valid   = count_ff != '0;
   assign rsp.kind    = head.kind;
   assign rsp.address = q_addr_ff[rd_ptr_ff];
   assign rsp.pixel   = head.pixel;
   assign rsp.width   = head.width;
   assign rsp.height  = head.height;
   assign rsp.beyond  = q_bey_ff[rd_ptr_ff];
   assign rsp.last    = head.last;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(RSP_DEPTH))
      else $error("result queue overflow");

   a_no_push_idle: assert property (@(posedge clock) disable iff (reset)
      !fire |-> push_count == 2'd0)
      else $error("push without a processed request");

   a_eof_result: assert property (@(posedge clock) disable iff (reset)
      fire && eof_ff |-> push_count != 2'd0)
      else $error("end of file gave no finish result");

   a_pair_ends: assert property (@(posedge clock) disable iff (reset)
      push_count == 2'd2 |-> res_b.last && eof_ff)
      else $error("second result is not a finish");

endmodule
